>>> rtl/core/ndrp_pkg.sv
// Shared types, constants and helpers for the node discovery response parser.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package ndrp_pkg;

  // Default configuration and limits
  localparam int RECORD_LEN_DEF = 48;
  localparam int MAX_NODES_DEF  = 8;
  localparam int MAX_NODES_LIM  = 16;

  // Field widths of the channels
  localparam int CHAR_W     = 8;
  localparam int SLOT_W     = 3;
  localparam int ADDR_W     = 64;
  localparam int STRENGTH_W = 8;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Command word widths, sized for the largest table
  localparam int SLOT_IDX_W = $clog2(MAX_NODES_LIM);
  localparam int CNT_MAX_W  = $clog2(MAX_NODES_LIM + 1);

  // Record layout
  localparam logic [CHAR_W-1:0] SYNC_CHAR = 8'h46;
  localparam int ADDR_HI_OFS  = 5;
  localparam int ADDR_LO_OFS  = 14;
  localparam int ADDR_DIGITS  = 8;
  localparam int STRENGTH_OFS = 46;

  // Register map
  localparam logic [PADDR_W-1:0] REG_RESPONSE_MODE = 3'd0;

  // Command word from the front end to the table/emit engine
  typedef struct packed {
    logic                    store;
    logic                    emit;
    logic [SLOT_IDX_W-1:0]   slot;
    logic [ADDR_W-1:0]       addr;
    logic [STRENGTH_W-1:0]   strength;
    logic                    bad;
    logic [CNT_MAX_W-1:0]    count;
    logic                    nbr;
  } cmd_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND,
    BK_REJECT
  } bk_state_e;

  // Hex digit decode: value in [3:0], valid flag in [4]
  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ndrp_if.sv
// Handshake channels of the parser: character input and table result output.
// Depends on ndrp_pkg for field widths.
`default_nettype none

interface ndrp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ndrp_pkg::CHAR_W-1:0]  char_in;
  logic                         final_char;

  modport source (output valid, output char_in, output final_char, input ready);
  modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

interface ndrp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [ndrp_pkg::SLOT_W-1:0]      slot;
  logic [ndrp_pkg::ADDR_W-1:0]      address;
  logic [ndrp_pkg::STRENGTH_W-1:0]  strength;
  logic                             bad_digit;
  logic                             truncated;
  logic                             last_result;

  modport source (output valid, output status, output slot, output address,
                  output strength, output bad_digit, output truncated,
                  output last_result, input ready);
  modport sink   (input valid, input status, input slot, input address,
                  input strength, input bad_digit, input truncated,
                  input last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/core/node_discovery_response_parser.sv
// Node discovery response parser: takes one ASCII character per accepted word
// and, at the last character of a response, emits one word per table slot
// (MAX_NODES-1 words) or a single rejection word. The front end takes one
// character per cycle while the two-word command queue has room; it stalls
// only when a response end is still being emitted and two more commands wait.
// Emission runs through a registered table read for each result (BK_READ, then
// BK_SEND) and waits on output backpressure; a rejection is sent from BK_REJECT.
// Register 0 at byte address 0 (bit 0) selects neighbor mode; write it only
// while the block is idle.
// Depends on ndrp_pkg, ndrp_if, ndrp_front, ndrp_cmd_fifo and ndrp_back.
`default_nettype none

module node_discovery_response_parser #(
  parameter int RECORD_LEN = ndrp_pkg::RECORD_LEN_DEF,
  parameter int MAX_NODES  = ndrp_pkg::MAX_NODES_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  ndrp_in_if.sink                         in_ch,
  ndrp_out_if.source                      out_ch,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [ndrp_pkg::PADDR_W-1:0]     paddr,
  input  wire [ndrp_pkg::PDATA_W-1:0]     pwdata,
  output logic [ndrp_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import ndrp_pkg::*;

  logic mode_q;
  logic reg_hit;

  logic fq_push_valid, fq_push_ready, fq_pop_valid, fq_pop_ready;
  cmd_t fq_push_data, fq_pop_data;

  // Config register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_RESPONSE_MODE[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

  // Character parser
  ndrp_front #(
    .RECORD_LEN (RECORD_LEN),
    .MAX_NODES  (MAX_NODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_ch       (in_ch),
    .cmd_valid_o (fq_push_valid),
    .cmd_ready_i (fq_push_ready),
    .cmd_o       (fq_push_data)
  );

  // Command queue
  ndrp_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_push_valid),
    .push_ready_o (fq_push_ready),
    .push_data_i  (fq_push_data),
    .pop_valid_o  (fq_pop_valid),
    .pop_ready_i  (fq_pop_ready),
    .pop_data_o   (fq_pop_data)
  );

  // Table and emitter
  ndrp_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fq_pop_valid),
    .cmd_ready_o (fq_pop_ready),
    .cmd_i       (fq_pop_data),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/core/ndrp_front.sv
// Front end: aligns on the sync character, cuts records and decodes hex fields.
// Depends on ndrp_pkg and ndrp_in_if; emits cmd_t words toward the queue.
`default_nettype none

module ndrp_front #(
  parameter int RECORD_LEN = ndrp_pkg::RECORD_LEN_DEF,
  parameter int MAX_NODES  = ndrp_pkg::MAX_NODES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 mode_i,
  ndrp_in_if.sink             in_ch,
  output logic                cmd_valid_o,
  input  wire                 cmd_ready_i,
  output ndrp_pkg::cmd_t      cmd_o
);
  import ndrp_pkg::*;

  localparam int POS_W = $clog2(RECORD_LEN);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int SLOTS = MAX_NODES - 1;

  logic                  aligned_q, aligned_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [STRENGTH_W-1:0] str_q, str_d;
  logic                  bad_q, bad_d;

  logic                  acc, go, rec_end, in_addr, in_str, store;
  logic [4:0]            hex;
  logic [CNT_W-1:0]      cnt_inc, cnt_end;
  logic [ADDR_W-1:0]     addr_n;
  logic [STRENGTH_W-1:0] str_n;
  logic                  bad_n;

  // Input is taken whenever the queue has room
  assign in_ch.ready = cmd_ready_i;
  assign acc         = in_ch.valid & cmd_ready_i;

  // Field decode for the current character
  always_comb begin
    go      = aligned_q | (in_ch.char_in == SYNC_CHAR);
    hex     = hex_decode(in_ch.char_in);
    in_addr = (pos_q >= POS_W'(ADDR_HI_OFS) && pos_q < POS_W'(ADDR_HI_OFS + ADDR_DIGITS)) ||
              (pos_q >= POS_W'(ADDR_LO_OFS) && pos_q < POS_W'(ADDR_LO_OFS + ADDR_DIGITS));
    in_str  = mode_i && (pos_q == POS_W'(STRENGTH_OFS) || pos_q == POS_W'(STRENGTH_OFS + 1));
    addr_n  = in_addr ? {addr_q[ADDR_W-5:0], hex[3:0]} : addr_q;
    str_n   = in_str ? {str_q[STRENGTH_W-5:0], hex[3:0]} : str_q;
    bad_n   = bad_q | ((in_addr | in_str) & ~hex[4]);
    rec_end = go && (pos_q == POS_W'(RECORD_LEN - 1));
    cnt_inc = (cnt_q < CNT_W'(SLOTS + 1)) ? cnt_q + CNT_W'(1) : cnt_q;
    cnt_end = rec_end ? cnt_inc : cnt_q;
    store   = rec_end && (cnt_q < CNT_W'(SLOTS));
  end

  // Command word: table write and/or end-of-response emit
  always_comb begin
    cmd_valid_o    = acc & (store | in_ch.final_char);
    cmd_o.store    = store;
    cmd_o.emit     = in_ch.final_char;
    cmd_o.slot     = SLOT_IDX_W'(cnt_q);
    cmd_o.addr     = addr_n;
    cmd_o.strength = str_n;
    cmd_o.bad      = bad_n;
    cmd_o.count    = CNT_MAX_W'(cnt_end);
    cmd_o.nbr      = mode_i;
  end

  // Parse state update
  always_comb begin
    aligned_d = aligned_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    str_d     = str_q;
    bad_d     = bad_q;
    if (acc) begin
      if (in_ch.final_char) begin
        aligned_d = 1'b0;
        pos_d     = '0;
        cnt_d     = '0;
        addr_d    = '0;
        str_d     = '0;
        bad_d     = 1'b0;
      end else if (go) begin
        aligned_d = 1'b1;
        if (rec_end) begin
          pos_d  = '0;
          cnt_d  = cnt_inc;
          addr_d = '0;
          str_d  = '0;
          bad_d  = 1'b0;
        end else begin
          pos_d  = pos_q + POS_W'(1);
          addr_d = addr_n;
          str_d  = str_n;
          bad_d  = bad_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aligned_q <= 1'b0;
      pos_q     <= '0;
      cnt_q     <= '0;
      addr_q    <= '0;
      str_q     <= '0;
      bad_q     <= 1'b0;
    end else begin
      aligned_q <= aligned_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      addr_q    <= addr_d;
      str_q     <= str_d;
      bad_q     <= bad_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ndrp_cmd_fifo.sv
// Two-word command queue between the parser front end and the table engine.
// Depends on ndrp_pkg for the cmd_t word.
`default_nettype none

module ndrp_cmd_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_valid_i,
  output logic            push_ready_o,
  input  ndrp_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  wire             pop_ready_i,
  output ndrp_pkg::cmd_t  pop_data_o
);
  import ndrp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ndrp_back.sv
// Back end: node table and result emitter, one table read per result.
// Depends on ndrp_pkg and ndrp_out_if; consumes cmd_t words from the queue.
`default_nettype none

module ndrp_back #(
  parameter int MAX_NODES = ndrp_pkg::MAX_NODES_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cmd_valid_i,
  output logic            cmd_ready_o,
  input  ndrp_pkg::cmd_t  cmd_i,
  ndrp_out_if.source      out_ch
);
  import ndrp_pkg::*;

  localparam int SLOTS = MAX_NODES - 1;
  localparam int IDX_W = $clog2(MAX_NODES);

  // Node table
  logic [ADDR_W-1:0]     tbl_addr [SLOTS];
  logic [STRENGTH_W-1:0] tbl_str  [SLOTS];
  logic                  tbl_bad  [SLOTS];

  logic [ADDR_W-1:0]     rd_addr_q;
  logic [STRENGTH_W-1:0] rd_str_q;
  logic                  rd_bad_q;

  bk_state_e             state_q, state_d;
  logic [IDX_W-1:0]      k_q;
  logic [CNT_MAX_W-1:0]  cnt_q;
  logic                  nbr_q, over_q;

  logic                  out_valid_q;
  logic                  out_status_q, out_bad_q, out_trunc_q, out_last_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic [STRENGTH_W-1:0] out_str_q;

  logic cmd_over, out_free, k_last, filled;
  logic tbl_we, rd_en, latch_emit, load_slot, load_rej, k_inc;

  assign cmd_over = cmd_i.count > CNT_MAX_W'(SLOTS);
  assign out_free = ~out_valid_q | out_ch.ready;
  assign k_last   = (k_q == IDX_W'(SLOTS - 1));
  assign filled   = CNT_MAX_W'(k_q) < cnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.emit) begin
          state_d = (cmd_over && !cmd_i.nbr) ? BK_REJECT : BK_READ;
        end
      end
      BK_READ:   state_d = BK_SEND;
      BK_SEND: begin
        if (out_free) state_d = k_last ? BK_IDLE : BK_READ;
      end
      BK_REJECT: begin
        if (out_free) state_d = BK_IDLE;
      end
      default:   state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    tbl_we      = 1'b0;
    latch_emit  = 1'b0;
    rd_en       = 1'b0;
    load_slot   = 1'b0;
    load_rej    = 1'b0;
    k_inc       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        tbl_we      = cmd_valid_i & cmd_i.store;
        latch_emit  = cmd_valid_i & cmd_i.emit;
      end
      BK_READ:   rd_en = 1'b1;
      BK_SEND: begin
        load_slot = out_free;
        k_inc     = out_free & ~k_last;
      end
      BK_REJECT: load_rej = out_free;
      default: ;
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_addr[cmd_i.slot[IDX_W-1:0]] <= cmd_i.addr;
      tbl_str[cmd_i.slot[IDX_W-1:0]]  <= cmd_i.strength;
      tbl_bad[cmd_i.slot[IDX_W-1:0]]  <= cmd_i.bad;
    end
    if (rd_en) begin
      rd_addr_q <= tbl_addr[k_q];
      rd_str_q  <= tbl_str[k_q];
      rd_bad_q  <= tbl_bad[k_q];
    end
  end

  // Emit context, captured at the end-of-response command
  always_ff @(posedge clk_i) begin
    if (latch_emit) begin
      cnt_q  <= cmd_i.count;
      nbr_q  <= cmd_i.nbr;
      over_q <= cmd_over;
    end
  end

  // Sequencer state and slot index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (latch_emit) begin
        k_q <= '0;
      end else if (k_inc) begin
        k_q <= k_q + IDX_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_slot | load_rej) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_slot) begin
      out_status_q <= 1'b0;
      out_slot_q   <= SLOT_W'(k_q);
      out_addr_q   <= filled ? rd_addr_q : '0;
      out_str_q    <= (filled && nbr_q) ? rd_str_q : '0;
      out_bad_q    <= filled & rd_bad_q;
      out_trunc_q  <= over_q;
      out_last_q   <= k_last;
    end else if (load_rej) begin
      out_status_q <= 1'b1;
      out_slot_q   <= '0;
      out_addr_q   <= '0;
      out_str_q    <= '0;
      out_bad_q    <= 1'b0;
      out_trunc_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.slot        = out_slot_q;
  assign out_ch.address     = out_addr_q;
  assign out_ch.strength    = out_str_q;
  assign out_ch.bad_digit   = out_bad_q;
  assign out_ch.truncated   = out_trunc_q;
  assign out_ch.last_result = out_last_q;

endmodule

`default_nettype wire
